// ===== design/mfps_pkg.sv =====
package mfps_pkg;

    localparam int MAX_COLS_DEF = 256;
    localparam int COLS_W       = 9;
    localparam int CELL_W       = 16;
    localparam int SUM_W        = 32;

    localparam logic [COLS_W-1:0] COLS_RESET = 9'd256;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Per-cell control that travels with the data through the front stages
    typedef struct packed {
        logic valid;
        logic first;      // cell belongs to the first row of the matrix
        logic fresh;      // cell opens a row, so the row maximum restarts
        logic last;       // cell closes the matrix
        logic has_left;
        logic has_right;
    } issue_t;

    // Control for a finished sum on its way to the row maximum
    typedef struct packed {
        logic valid;
        logic fresh;
        logic last;
    } done_t;

endpackage

// ===== design/mfps_ram.sv =====
module mfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old word when the same address is written in that cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mfps_ctrl.sv =====
module mfps_ctrl #(
    parameter int MAX_COLS = mfps_pkg::MAX_COLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic [mfps_pkg::CELL_W-1:0]   cell_value,
    input  logic                          last_cell,
    input  logic                          cfg_wr_en,
    input  logic [mfps_pkg::COLS_W-1:0]   cfg_wr_data,
    output logic [$clog2(MAX_COLS)-1:0]   rd_addr_up,
    output logic [$clog2(MAX_COLS)-1:0]   rd_addr_right,
    output mfps_pkg::issue_t              s1_issue,
    output logic [$clog2(MAX_COLS)-1:0]   s1_col,
    output logic [mfps_pkg::CELL_W-1:0]   s1_cell
);

    localparam int IW   = $clog2(MAX_COLS);
    localparam int CNTW = $clog2(MAX_COLS + 1);
    localparam int CMPW = (CNTW > mfps_pkg::COLS_W) ? CNTW : mfps_pkg::COLS_W;

    logic [mfps_pkg::COLS_W-1:0] columns_reg;
    logic [IW-1:0]               col_idx_reg;
    logic [IW-1:0]               col_idx_next;
    logic                        first_row_reg;
    logic                        first_row_next;

    mfps_pkg::issue_t            s1_issue_reg;
    logic [IW-1:0]               s1_col_reg;
    logic [mfps_pkg::CELL_W-1:0] s1_cell_reg;

    logic [CMPW-1:0] cols_ext;
    logic [CMPW-1:0] eff_cols;
    logic [CMPW-1:0] col_next_ext;
    logic            wrap;
    logic            row_end;
    logic [IW-1:0]   col;
    logic            accept;
    mfps_pkg::issue_t issue;

    assign accept = advance && in_valid;

    always_comb
    begin
        cols_ext = CMPW'(columns_reg);
        if (columns_reg == '0)
        begin
            eff_cols = CMPW'(1);
        end
        else if (cols_ext > CMPW'(MAX_COLS))
        begin
            eff_cols = CMPW'(MAX_COLS);
        end
        else
        begin
            eff_cols = cols_ext;
        end

        // A shrunken row length restarts at column 0 in a later row
        wrap         = CMPW'(col_idx_reg) >= eff_cols;
        col          = wrap ? '0 : col_idx_reg;
        col_next_ext = CMPW'(col) + CMPW'(1);
        row_end      = col_next_ext >= eff_cols;

        issue.valid     = in_valid;
        issue.first     = first_row_reg && !wrap;
        issue.fresh     = (col == '0);
        issue.last      = last_cell;
        issue.has_left  = (col != '0);
        issue.has_right = !row_end;

        if (last_cell)
        begin
            col_idx_next   = '0;
            first_row_next = 1'b1;
        end
        else if (row_end)
        begin
            col_idx_next   = '0;
            first_row_next = 1'b0;
        end
        else
        begin
            col_idx_next   = col_next_ext[IW-1:0];
            first_row_next = issue.first;
        end
    end

    assign rd_addr_up    = col;
    assign rd_addr_right = col_next_ext[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg   <= mfps_pkg::COLS_RESET;
            col_idx_reg   <= '0;
            first_row_reg <= 1'b1;
            s1_issue_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                columns_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                col_idx_reg   <= col_idx_next;
                first_row_reg <= first_row_next;
            end
            if (advance)
            begin
                s1_issue_reg <= issue;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_col_reg  <= col;
            s1_cell_reg <= cell_value;
        end
    end

    assign s1_issue = s1_issue_reg;
    assign s1_col   = s1_col_reg;
    assign s1_cell  = s1_cell_reg;

endmodule

// ===== design/mfps_calc.sv =====
module mfps_calc #(
    parameter int MAX_COLS = mfps_pkg::MAX_COLS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  mfps_pkg::issue_t                   s1_issue,
    input  logic [$clog2(MAX_COLS)-1:0]        s1_col,
    input  logic [mfps_pkg::CELL_W-1:0]        s1_cell,
    input  logic [mfps_pkg::SUM_W-1:0]         up_raw,
    input  logic [mfps_pkg::SUM_W-1:0]         right_raw,
    output mfps_pkg::done_t                    s3_done,
    output logic [$clog2(MAX_COLS)-1:0]        s3_col,
    output logic signed [mfps_pkg::SUM_W-1:0]  s3_sum
);

    localparam int IW    = $clog2(MAX_COLS);
    localparam int SW    = mfps_pkg::SUM_W;
    localparam int CW    = mfps_pkg::CELL_W;

    // Stage 2
    mfps_pkg::issue_t     s2_issue_reg;
    logic [IW-1:0]        s2_col_reg;
    logic [CW-1:0]        s2_cell_reg;
    logic signed [SW-1:0] s2_up_reg;
    logic signed [SW-1:0] s2_right_reg;
    logic                 s2_up_hit_reg;
    logic                 s2_right_hit_reg;

    // Stage 3 and the write that just retired
    mfps_pkg::done_t      s3_done_reg;
    logic [IW-1:0]        s3_col_reg;
    logic signed [SW-1:0] s3_sum_reg;
    logic                 wb_valid_reg;
    logic [IW-1:0]        wb_col_reg;
    logic signed [SW-1:0] wb_sum_reg;

    logic signed [SW-1:0] left_reg;

    logic [IW-1:0]        s1_rcol;
    logic signed [SW-1:0] up_res;
    logic signed [SW-1:0] right_res;
    logic                 up_hit;
    logic                 right_hit;

    logic signed [SW-1:0] up_eff;
    logic signed [SW-1:0] right_eff;
    logic signed [SW-1:0] best;
    logic [SW:0]          wide;
    logic signed [SW-1:0] sum;
    mfps_pkg::done_t      done;

    // Stage 1: patch RAM data with sums not yet visible at read time
    always_comb
    begin
        s1_rcol = s1_col + IW'(1);

        if (s3_done_reg.valid && (s3_col_reg == s1_col))
        begin
            up_res = s3_sum_reg;
        end
        else if (wb_valid_reg && (wb_col_reg == s1_col))
        begin
            up_res = wb_sum_reg;
        end
        else
        begin
            up_res = up_raw;
        end

        if (s3_done_reg.valid && (s3_col_reg == s1_rcol))
        begin
            right_res = s3_sum_reg;
        end
        else if (wb_valid_reg && (wb_col_reg == s1_rcol))
        begin
            right_res = wb_sum_reg;
        end
        else
        begin
            right_res = right_raw;
        end

        // The cell one ahead is still adding; take its sum one stage later
        up_hit    = s2_issue_reg.valid && (s2_col_reg == s1_col);
        right_hit = s2_issue_reg.valid && (s2_col_reg == s1_rcol);
    end

    // Stage 2: best of up to three neighbors, add, saturate; a first-row cell takes its own value
    always_comb
    begin
        up_eff    = s2_up_hit_reg ? s3_sum_reg : s2_up_reg;
        right_eff = s2_right_hit_reg ? s3_sum_reg : s2_right_reg;

        best = up_eff;
        if (s2_issue_reg.has_left && (left_reg > best))
        begin
            best = left_reg;
        end
        if (s2_issue_reg.has_right && (right_eff > best))
        begin
            best = right_eff;
        end

        wide = {best[SW-1], best} + {{(SW + 1 - CW){s2_cell_reg[CW-1]}}, s2_cell_reg};

        if (s2_issue_reg.first)
        begin
            sum = {{(SW - CW){s2_cell_reg[CW-1]}}, s2_cell_reg};
        end
        else if (wide[SW] != wide[SW-1])
        begin
            sum = wide[SW] ? mfps_pkg::SUM_MIN : mfps_pkg::SUM_MAX;
        end
        else
        begin
            sum = wide[SW-1:0];
        end

        done.valid = s2_issue_reg.valid;
        done.fresh = s2_issue_reg.fresh;
        done.last  = s2_issue_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_issue_reg <= '0;
            s3_done_reg  <= '0;
            wb_valid_reg <= 1'b0;
            left_reg     <= '0;
        end
        else if (advance)
        begin
            s2_issue_reg <= s1_issue;
            s3_done_reg  <= done;
            wb_valid_reg <= s3_done_reg.valid;
            if (s2_issue_reg.valid)
            begin
                left_reg <= up_eff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_col_reg       <= s1_col;
            s2_cell_reg      <= s1_cell;
            s2_up_reg        <= up_res;
            s2_right_reg     <= right_res;
            s2_up_hit_reg    <= up_hit;
            s2_right_hit_reg <= right_hit;
            s3_col_reg       <= s2_col_reg;
            s3_sum_reg       <= sum;
            wb_col_reg       <= s3_col_reg;
            wb_sum_reg       <= s3_sum_reg;
        end
    end

    assign s3_done = s3_done_reg;
    assign s3_col  = s3_col_reg;
    assign s3_sum  = s3_sum_reg;

endmodule

// ===== design/mfps_reduce.sv =====
module mfps_reduce (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  mfps_pkg::done_t                   s3_done,
    input  logic signed [mfps_pkg::SUM_W-1:0] s3_sum,
    output logic                              out_valid,
    output logic [mfps_pkg::SUM_W-1:0]        max_sum
);

    logic signed [mfps_pkg::SUM_W-1:0] row_best_reg;
    logic signed [mfps_pkg::SUM_W-1:0] row_best_next;
    logic                              out_valid_reg;
    logic [mfps_pkg::SUM_W-1:0]        max_sum_reg;

    // A cell that opens a row restarts the maximum
    always_comb
    begin
        if (s3_done.fresh || (s3_sum > row_best_reg))
        begin
            row_best_next = s3_sum;
        end
        else
        begin
            row_best_next = row_best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_best_reg  <= mfps_pkg::SUM_MIN;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (s3_done.valid)
            begin
                row_best_reg <= row_best_next;
            end
            out_valid_reg <= s3_done.valid && s3_done.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            max_sum_reg <= row_best_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign max_sum   = max_sum_reg;

endmodule

// ===== design/max_falling_path_sum.sv =====
// Streaming maximum falling path sum.
//
// Input channel (in_valid / in_stall): one matrix cell per beat in row-major
// order, cell_value signed 16 bits, last_cell marking the final cell. Output
// channel (out_valid / out_stall): one beat carrying max_sum, the saturated
// best path sum over the row that holds the last cell (only the cells of
// that row received so far). Cells without last_cell produce no beat.
// cfg_wr_en / cfg_wr_data load the row length (0 acts as 1, values above
// MAX_COLS act as MAX_COLS); write it only while no beat is in flight.
//
// Throughput is one cell per cycle while no result is held by out_stall. A
// result passes row RAM read, neighbor max plus saturating add, row maximum
// and output register after its last cell is accepted. The tightest loop is
// the add stage, which feeds its sum straight back for narrow rows.
// Previous-row sums live in two copies of a MAX_COLS-deep RAM so both the
// cell above and its right neighbor are read each cycle the pipe advances.
//
// Reset clears the pipeline, sets the row length to 256 and starts a new
// matrix; no clearing pass is needed. While out_stall holds a waiting
// result, the whole pipeline freezes and in_stall is raised.
module max_falling_path_sum #(
    parameter int MAX_COLS = mfps_pkg::MAX_COLS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [mfps_pkg::CELL_W-1:0] cell_value,
    input  logic                              last_cell,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [mfps_pkg::SUM_W-1:0] max_sum,
    input  logic                              cfg_wr_en,
    input  logic [mfps_pkg::COLS_W-1:0]       cfg_wr_data
);

    localparam int IW = $clog2(MAX_COLS);

    logic                              advance;
    logic [IW-1:0]                     rd_addr_up;
    logic [IW-1:0]                     rd_addr_right;
    mfps_pkg::issue_t                  s1_issue;
    logic [IW-1:0]                     s1_col;
    logic [mfps_pkg::CELL_W-1:0]       s1_cell;
    logic [mfps_pkg::SUM_W-1:0]        up_raw;
    logic [mfps_pkg::SUM_W-1:0]        right_raw;
    mfps_pkg::done_t                   s3_done;
    logic [IW-1:0]                     s3_col;
    logic signed [mfps_pkg::SUM_W-1:0] s3_sum;
    logic                              wr_en;
    logic [mfps_pkg::SUM_W-1:0]        max_sum_raw;

    // Advance everything together; hold the whole pipe while a result waits
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    // Write each finished sum back into its column as it leaves stage 3
    assign wr_en = advance && s3_done.valid;

    mfps_ctrl #(
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (in_valid),
        .cell_value    (cell_value),
        .last_cell     (last_cell),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .rd_addr_up    (rd_addr_up),
        .rd_addr_right (rd_addr_right),
        .s1_issue      (s1_issue),
        .s1_col        (s1_col),
        .s1_cell       (s1_cell)
    );

    mfps_ram #(
        .WIDTH (mfps_pkg::SUM_W),
        .DEPTH (MAX_COLS)
    ) u_ram_up (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s3_col),
        .wdata (s3_sum),
        .re    (advance),
        .raddr (rd_addr_up),
        .rdata (up_raw)
    );

    mfps_ram #(
        .WIDTH (mfps_pkg::SUM_W),
        .DEPTH (MAX_COLS)
    ) u_ram_right (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s3_col),
        .wdata (s3_sum),
        .re    (advance),
        .raddr (rd_addr_right),
        .rdata (right_raw)
    );

    mfps_calc #(
        .MAX_COLS (MAX_COLS)
    ) u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .s1_issue  (s1_issue),
        .s1_col    (s1_col),
        .s1_cell   (s1_cell),
        .up_raw    (up_raw),
        .right_raw (right_raw),
        .s3_done   (s3_done),
        .s3_col    (s3_col),
        .s3_sum    (s3_sum)
    );

    mfps_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .s3_done   (s3_done),
        .s3_sum    (s3_sum),
        .out_valid (out_valid),
        .max_sum   (max_sum_raw)
    );

    assign max_sum = max_sum_raw;

endmodule

// ===== tb/path_sum_board_pkg.sv =====
package path_sum_board_pkg;

    // Tracks the path sums of the matrix on its way in and holds the row
    // maxima that the block still owes.
    class path_sum_board;

        logic signed [mfps_pkg::SUM_W-1:0] prev_row [mfps_pkg::MAX_COLS_DEF];
        int unsigned                       col_pos;
        bit                                first_row;
        logic signed [mfps_pkg::SUM_W-1:0] left_above;
        logic signed [mfps_pkg::SUM_W-1:0] best_in_row;
        logic [mfps_pkg::COLS_W-1:0]       columns_reg;
        logic signed [mfps_pkg::SUM_W-1:0] due_sums [$];
        int                                errors;

        function new();
            columns_reg = mfps_pkg::COLS_RESET;
            errors      = 0;
            restart();
        endfunction

        function void restart();
            col_pos     = 0;
            first_row   = 1'b1;
            left_above  = '0;
            best_in_row = mfps_pkg::SUM_MIN;
        endfunction

        function void set_columns(logic [mfps_pkg::COLS_W-1:0] value);
            columns_reg = value;
        endfunction

        // 0 acts as one column, anything past the array depth as the full depth
        function int unsigned row_len();
            if (columns_reg == 0)
            begin
                return 1;
            end
            if (columns_reg > mfps_pkg::MAX_COLS_DEF)
            begin
                return mfps_pkg::MAX_COLS_DEF;
            end
            return 32'(columns_reg);
        endfunction

        function int pending();
            return due_sums.size();
        endfunction

        function void take_cell(logic signed [mfps_pkg::CELL_W-1:0] value, logic fin);
            int unsigned                       n;
            int unsigned                       j;
            logic signed [mfps_pkg::SUM_W-1:0] above;
            logic signed [mfps_pkg::SUM_W-1:0] pick;
            logic signed [mfps_pkg::SUM_W-1:0] sum;
            longint                            wide;

            n = row_len();
            if (col_pos >= n)
            begin
                col_pos     = 0;
                first_row   = 1'b0;
                best_in_row = mfps_pkg::SUM_MIN;
            end
            j     = col_pos;
            above = prev_row[j];

            if (first_row)
            begin
                sum = {{(mfps_pkg::SUM_W - mfps_pkg::CELL_W){value[mfps_pkg::CELL_W-1]}},
                       value};
            end
            else
            begin
                pick = above;
                if (j >= 1 && left_above > pick)
                begin
                    pick = left_above;
                end
                if (j + 1 < n && prev_row[j + 1] > pick)
                begin
                    pick = prev_row[j + 1];
                end
                wide = longint'(pick) + longint'(value);
                if (wide > longint'(mfps_pkg::SUM_MAX))
                begin
                    sum = mfps_pkg::SUM_MAX;
                end
                else if (wide < longint'(mfps_pkg::SUM_MIN))
                begin
                    sum = mfps_pkg::SUM_MIN;
                end
                else
                begin
                    sum = wide[mfps_pkg::SUM_W-1:0];
                end
            end

            left_above  = above;
            prev_row[j] = sum;
            if (sum > best_in_row)
            begin
                best_in_row = sum;
            end

            if (fin)
            begin
                due_sums.push_back(best_in_row);
                restart();
            end
            else if (j + 1 >= n)
            begin
                col_pos     = 0;
                first_row   = 1'b0;
                best_in_row = mfps_pkg::SUM_MIN;
            end
            else
            begin
                col_pos = j + 1;
            end
        endfunction

        function void match_sum(logic signed [mfps_pkg::SUM_W-1:0] got);
            logic signed [mfps_pkg::SUM_W-1:0] want;

            if (due_sums.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("max_sum %0d arrived with nothing outstanding", got);
                end
                return;
            end
            want = due_sums.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("max_sum mismatch: expected %0d, got %0d", want, got);
                end
            end
        endfunction

    endclass

endpackage

// ===== tb/tb_max_falling_path_sum.sv =====
module tb_max_falling_path_sum;

    localparam int CELL_W = mfps_pkg::CELL_W;
    localparam int SUM_W  = mfps_pkg::SUM_W;
    localparam int COLS_W = mfps_pkg::COLS_W;

    // Margin after the last owed result so in-flight cells clear
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int LONG_HOLD     = 200;
    localparam int RANDOM_CELLS  = 560;
    localparam int RANDOM_SUMS   = 20;
    localparam int QUIET_TAIL    = 120;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [CELL_W-1:0] cell_value;
    logic                     last_cell;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [SUM_W-1:0]  max_sum;
    logic                     cfg_wr_en;
    logic [COLS_W-1:0]        cfg_wr_data;

    path_sum_board_pkg::path_sum_board board = new();

    bit idling;     // random gaps allowed on both channels
    bit gaps_here;  // sender gaps allowed for the matrix being sent
    bit hold_req;   // ask the receiver for one long hold-off
    bit hold_on;    // the long hold-off has started
    int cells_sent;

    max_falling_path_sum dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_value (cell_value),
        .last_cell  (last_cell),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .max_sum    (max_sum),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #20000000;
        $display("tb_max_falling_path_sum failed");
        $finish;
    end

    // Feed every accepted cell beat to the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            board.take_cell(cell_value, last_cell);
        end
    end

    // Check every accepted result beat against the oldest owed row maximum
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.match_sum(max_sum);
        end
    end

    // Receiver: alternate free-running stretches with stall bursts while idling;
    // on request, hold off for a long stretch so the pipeline backs up.
    initial
    begin
        int hold;

        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                @(posedge clk);
                hold_on = 1'b1;
                for (hold = 1; hold < LONG_HOLD; hold++)
                begin
                    @(posedge clk);
                end
                hold_req = 1'b0;
                hold_on  = 1'b0;
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Pick a cell value: extremes, small values around zero, or anything
    function automatic logic signed [CELL_W-1:0] rand_cell();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return CELL_W'($signed($urandom_range(0, 100)) - 50);
            default: return CELL_W'($urandom);
        endcase
    endfunction

    // Pick a row length, mostly narrow; now and then zero or out of range
    function automatic logic [COLS_W-1:0] rand_columns();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return COLS_W'($urandom_range(257, 511));
            2:       return COLS_W'($urandom_range(200, 256));
            3:       return COLS_W'(1);
            default: return COLS_W'($urandom_range(2, 12));
        endcase
    endfunction

    // Offer one cell beat, maybe after a gap, and hold it until accepted
    task automatic send_cell(input logic signed [CELL_W-1:0] value, input logic fin);
        if (idling && gaps_here && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cell_value <= value;
        last_cell  <= fin;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        cells_sent++;
    endtask

    // Send full rows and then tail cells of the final row, last one flagged
    task automatic send_matrix(input int rows, input int tail);
        int cols;
        int total;
        int k;

        cols      = board.row_len();
        total     = (rows - 1) * cols + tail;
        gaps_here = $urandom_range(0, 2) != 0;
        for (k = 0; k < total; k++)
        begin
            send_cell(rand_cell(), k == total - 1);
        end
    endtask

    // Drop valid, wait for every owed result, then let in-flight cells clear
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load the row length; only call while the block is idle
    task automatic write_columns(input logic [COLS_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        board.set_columns(value);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int k;
        int random_base;
        int sums_base;
        int phase_left;
        int cols;

        in_valid    = 1'b0;
        cell_value  = '0;
        last_cell   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        idling      = 1'b1;
        gaps_here   = 1'b1;
        hold_req    = 1'b0;
        hold_on     = 1'b0;
        cells_sent  = 0;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-cell matrices at the value extremes, default row length
        send_cell(16'sh7FFF, 1'b1);
        send_cell(16'sh8000, 1'b1);
        settle();

        // Zero columns acts as one: each cell stacks on the one above
        write_columns('0);
        send_cell(16'sd5, 1'b0);
        send_cell(-16'sd7, 1'b0);
        send_cell(16'sh7FFF, 1'b1);
        settle();

        // Three columns: exercise left, right and straight-up neighbors
        write_columns(COLS_W'(3));
        send_cell(16'sd1, 1'b0);
        send_cell(16'sd9, 1'b0);
        send_cell(16'sd2, 1'b0);
        send_cell(-16'sd3, 1'b0);
        send_cell(16'sd0, 1'b0);
        send_cell(16'sh7FFF, 1'b1);
        settle();

        // Shrink the row mid-matrix: the next cell wraps into a new row
        write_columns(COLS_W'(4));
        send_cell(16'sd10, 1'b0);
        send_cell(16'sd20, 1'b0);
        send_cell(16'sd30, 1'b0);
        settle();
        write_columns(COLS_W'(2));
        send_cell(-16'sd1, 1'b0);
        send_cell(16'sd4, 1'b1);
        settle();

        // Out-of-range row lengths clamp to the full depth
        write_columns(COLS_W'(300));
        send_cell(16'sh8000, 1'b0);
        send_cell(16'sh7FFF, 1'b1);
        settle();
        write_columns(COLS_W'(511));
        send_cell(-16'sd1, 1'b1);
        settle();

        // Back-pressure: once the long hold-off is running, park a result
        // and keep offering cells until the block stalls its input
        write_columns(COLS_W'(8));
        gaps_here = 1'b0;
        hold_req  = 1'b1;
        wait (hold_on);
        send_cell(rand_cell(), 1'b1);
        for (k = 0; k < 48; k++)
        begin
            send_cell(rand_cell(), k == 47);
        end
        settle();

        // Random matrices in phases, each phase at its own row length
        random_base = cells_sent;
        sums_base   = 0;
        phase_left  = 0;
        while (cells_sent - random_base < RANDOM_CELLS || sums_base < RANDOM_SUMS)
        begin
            if (phase_left == 0)
            begin
                settle();
                write_columns(rand_columns());
                phase_left = $urandom_range(1, 6);
            end
            if (cells_sent - random_base > RANDOM_CELLS - QUIET_TAIL)
            begin
                idling = 1'b0;
            end
            cols = board.row_len();
            if (cols > 16)
            begin
                // Wide rows: keep them short and often end inside the first row
                send_matrix($urandom_range(1, 2), $urandom_range(1, cols));
                phase_left = 1;
            end
            else
            begin
                send_matrix($urandom_range(1, 5), $urandom_range(1, cols));
            end
            phase_left--;
            sums_base++;
        end

        // Drain with a bound, then report
        in_valid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && board.pending() != 0; k++)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("tb_max_falling_path_sum passed");
        end
        else
        begin
            $display("tb_max_falling_path_sum failed");
        end
        $finish;
    end

endmodule
